// File: rtl/core/nlru_pkg.sv
// Shared types and constants for the near-LRU insertion replacement block.
package nlru_pkg;

  // Default sizing
  localparam int DEF_SETS      = 1024;
  localparam int DEF_WAYS      = 16;
  localparam int DEF_TICK_BITS = 32;

  // Field widths fixed by the interface
  localparam int OP_W    = 2;
  localparam int SETIN_W = 10;
  localparam int WAYIN_W = 4;
  localparam int TICK_W  = 32;
  localparam int RANK_W  = 5;

  localparam logic [RANK_W-1:0] RANK_RESET = 5'd10;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TOUCH = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_INVAL = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  // Status a sort cell hands to its right neighbor
  typedef struct packed {
    logic vld;  // cell holds an entry
    logic lt;   // incoming stamp sorts before this cell's entry
  } nlru_link_t;

endpackage

// File: rtl/core/nlru_cell.sv
// One insertion-sort cell: holds a stamp and its way, shifts right on insert.
module nlru_cell
  import nlru_pkg::*;
#(
  parameter int TICK_BITS = DEF_TICK_BITS,
  parameter int WAY_W     = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 en,
  input  logic [TICK_BITS-1:0] in_val,
  input  logic [WAY_W-1:0]     in_way,
  input  nlru_link_t           left,
  input  logic [TICK_BITS-1:0] left_val,
  input  logic [WAY_W-1:0]     left_way,
  output nlru_link_t           link,
  output logic [TICK_BITS-1:0] val,
  output logic [WAY_W-1:0]     way
);

  logic vld;
  logic lt;
  logic take_new;
  logic take_left;

  // Strict compare keeps equal stamps in arrival order (lowest way first)
  assign lt        = !vld || (in_val < val);
  assign take_new  = lt && !left.lt;
  assign take_left = lt && left.lt;
  assign link      = '{vld: vld, lt: lt};

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= 1'b0;
    end else if (en) begin
      if (take_new) begin
        vld <= 1'b1;
      end else if (take_left) begin
        vld <= left.vld;
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (en) begin
      if (take_new) begin
        val <= in_val;
        way <= in_way;
      end else if (take_left) begin
        val <= left_val;
        way <= left_way;
      end
    end
  end

endmodule

// File: rtl/core/nlru_chain.sv
// Row of sort cells; ranks one set's stamps as they stream in, one per cycle while en is high.
module nlru_chain
  import nlru_pkg::*;
#(
  parameter int WAYS      = DEF_WAYS,
  parameter int TICK_BITS = DEF_TICK_BITS,
  parameter int WAY_W     = $clog2(WAYS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 en,
  input  logic [TICK_BITS-1:0] in_val,
  input  logic [WAY_W-1:0]     in_way,
  input  logic [WAY_W-1:0]     k_idx,
  output logic [TICK_BITS-1:0] kth_val,
  output logic [WAY_W-1:0]     min_way
);

  nlru_link_t           link [WAYS];
  logic [TICK_BITS-1:0] val  [WAYS];
  logic [WAY_W-1:0]     way  [WAYS];

  // Head cell sees an empty left side
  nlru_cell #(.TICK_BITS(TICK_BITS), .WAY_W(WAY_W)) u_head (
    .clk      (clk),
    .rst      (rst),
    .clear    (clear),
    .en       (en),
    .in_val   (in_val),
    .in_way   (in_way),
    .left     ('{vld: 1'b0, lt: 1'b0}),
    .left_val ('0),
    .left_way ('0),
    .link     (link[0]),
    .val      (val[0]),
    .way      (way[0])
  );

  for (genvar i = 1; i < WAYS; i++) begin : g_cell
    nlru_cell #(.TICK_BITS(TICK_BITS), .WAY_W(WAY_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (clear),
      .en       (en),
      .in_val   (in_val),
      .in_way   (in_way),
      .left     (link[i-1]),
      .left_val (val[i-1]),
      .left_way (way[i-1]),
      .link     (link[i]),
      .val      (val[i]),
      .way      (way[i])
    );
  end

  // Head holds the oldest stamp; cell k-1 holds the k-th smallest
  assign min_way = way[0];
  assign kth_val = val[k_idx];

endmodule

// File: rtl/core/near_lru_insertion_replacement.sv
// Top level of the near-LRU insertion replacement block.
// After reset the block sweeps its timestamp memory to zero, one set per cycle,
// holding busy high; insert_rank writes are taken during that time. A command
// is taken when start is high and busy is low. Touch, insert and invalidate
// write one way of the set; a victim query reads the set's row and streams it
// one way per cycle through a row of WAYS sort cells. Where SETS or WAYS is
// below the range of set_index or way_index, the index is reduced by one
// subtraction per cycle before the command runs. Each result is shown for
// exactly one cycle with done high and cannot be stalled.
module near_lru_insertion_replacement
  import nlru_pkg::*;
#(
  parameter int SETS      = DEF_SETS,
  parameter int WAYS      = DEF_WAYS,
  parameter int TICK_BITS = DEF_TICK_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op,
  input  logic [SETIN_W-1:0] set_index,
  input  logic [WAYIN_W-1:0] way_index,
  input  logic [TICK_W-1:0]  now_tick,
  input  logic               insert_rank_we,
  input  logic [RANK_W-1:0]  insert_rank,
  output logic               done,
  output logic [WAYIN_W-1:0] victim_way,
  output logic [TICK_W-1:0]  rank_threshold_out
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = $clog2(WAYS);
  localparam int SQ_W  = (SET_W > SETIN_W) ? SET_W : SETIN_W;
  localparam int WQ_W  = (WAY_W > WAYIN_W) ? WAY_W : WAYIN_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RED   = 7'b0000100,
    S_WRITE = 7'b0001000,
    S_READ  = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [SET_W-1:0]           clr_cnt;
  logic [WAY_W-1:0]           scan_cnt;
  logic [RANK_W-1:0]          rank;
  logic [TICK_BITS-1:0]       rank_threshold;
  logic [OP_W-1:0]            op_q;
  logic [SQ_W-1:0]            set_q;
  logic [WQ_W-1:0]            way_q;
  logic [TICK_BITS-1:0]       tick_q;
  logic [WAYS-1:0][TICK_BITS-1:0] mem [SETS];
  logic [WAYS-1:0][TICK_BITS-1:0] row;
  logic [TICK_BITS-1:0]       wr_data;
  logic                       set_big;
  logic                       way_big;
  logic [6:0]                 k_clamp;
  logic [6:0]                 k_sel;
  logic [TICK_BITS-1:0]       kth_val;
  logic [WAY_W-1:0]           min_way;
  logic [63:0]                thr_wide;
  logic [63:0]                way_wide;
  logic                       accept;

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);
  assign set_big = (set_q >= SETS);
  assign way_big = (way_q >= WAYS);

  // Rank zero acts as one; ranks past the set size take the largest stamp
  always_comb begin
    k_clamp = (rank == '0) ? 7'd1 : 7'(rank);
    if (k_clamp > 7'(WAYS)) begin
      k_clamp = 7'(WAYS);
    end
    k_sel = k_clamp - 7'd1;
  end

  // Value written by the single-way commands
  always_comb begin
    case (op_q)
      OP_TOUCH:  wr_data = tick_q;
      OP_INSERT: wr_data = (rank_threshold == '1) ? rank_threshold
                                                  : rank_threshold + 1'b1;
      default:   wr_data = '0;
    endcase
  end

  // Control FSM
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == SET_W'(SETS - 1)) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_RED;
      S_RED: begin
        if (!set_big && !way_big) begin
          state_next = (op_q == OP_QUERY) ? S_READ : S_WRITE;
        end
      end
      S_WRITE: state_next = S_IDLE;
      S_READ:  state_next = S_SCAN;
      S_SCAN:  if (scan_cnt == WAY_W'(WAYS - 1)) state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clear sweep and scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      scan_cnt <= '0;
    end else begin
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  // Rank register
  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= RANK_RESET;
    end else if (insert_rank_we) begin
      rank <= insert_rank;
    end
  end

  // Command capture and index reduction
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op;
      set_q  <= SQ_W'(set_index);
      way_q  <= WQ_W'(way_index);
      tick_q <= TICK_BITS'(now_tick);
    end else if (state == S_RED) begin
      if (set_big) begin
        set_q <= set_q - SQ_W'(SETS);
      end
      if (way_big) begin
        way_q <= way_q - WQ_W'(WAYS);
      end
    end
  end

  // Timestamp memory: row-wide read into a shift register, per-way write
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      mem[clr_cnt] <= '0;
    end else if (state == S_WRITE) begin
      mem[set_q[SET_W-1:0]][way_q[WAY_W-1:0]] <= wr_data;
    end
    if (state == S_READ) begin
      row <= mem[set_q[SET_W-1:0]];
    end else if (state == S_SCAN) begin
      row <= {TICK_BITS'(0), row[WAYS-1:1]};
    end
  end

  // Sort chain, fed one way per scan cycle
  nlru_chain #(.WAYS(WAYS), .TICK_BITS(TICK_BITS), .WAY_W(WAY_W)) u_chain (
    .clk     (clk),
    .rst     (rst),
    .clear   (state == S_READ),
    .en      (state == S_SCAN),
    .in_val  (row[0]),
    .in_way  (scan_cnt),
    .k_idx   (k_sel[WAY_W-1:0]),
    .kth_val (kth_val),
    .min_way (min_way)
  );

  // Shared threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_threshold <= '0;
    end else if (state == S_FIN) begin
      rank_threshold <= kth_val;
    end
  end

  // Result transfer
  always_comb begin
    thr_wide = (state == S_FIN) ? 64'(kth_val) : 64'(rank_threshold);
    way_wide = 64'(min_way);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_WRITE) || (state == S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_WRITE) || (state == S_FIN)) begin
      victim_way         <= (state == S_FIN) ? way_wide[WAYIN_W-1:0] : '0;
      rank_threshold_out <= thr_wide[TICK_W-1:0];
    end
  end

endmodule
